[sv/page_frame_allocator_refcount_macros.svh]
// Assertion macros shared by the checker of the page frame allocator.
// Each macro expands to one labeled concurrent assertion on i_clk and i_rst_n.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pfa_pkg.sv]
// Types and constants of the page frame allocator.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package pfa_pkg;

    localparam int REQ_W      = 3;
    localparam int ADDR_W     = 24;
    localparam int STAT_W     = 2;
    localparam int RC_OUT_W   = 8;
    localparam int FREE_W     = 13;
    localparam int PAGE_SHIFT = 12;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    localparam logic [REQ_W-1:0] RQ_ALLOC = 3'd0;
    localparam logic [REQ_W-1:0] RQ_FREE  = 3'd1;
    localparam logic [REQ_W-1:0] RQ_INC   = 3'd2;
    localparam logic [REQ_W-1:0] RQ_DEC   = 3'd3;
    localparam logic [REQ_W-1:0] RQ_READ  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] phys_addr;
    } t_req;

endpackage

`default_nettype wire

[sv/pfa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/page_frame_allocator_refcount.sv]
// A request is accepted in ST_IDLE; ST_EXEC registers its result once no
// stalled result is pending. No new request is accepted until ST_EXEC ends,
// set by the read-modify-write of the link and count memories (read on
// accept, write back in ST_EXEC); a stalled result holds the next request there.
// Reset: synchronous; a sweep over all PAGES entries then rebuilds the free
// list and clears all counts, and no request is accepted until it ends.
`default_nettype none

module page_frame_allocator_refcount
    import pfa_pkg::*;
#(
    parameter int PAGES      = 4096,
    parameter int FIRST_PAGE = 256,
    parameter int REF_BITS   = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [ADDR_W-1:0]   i_phys_addr,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [STAT_W-1:0]   o_status,
    output logic      [ADDR_W-1:0]   o_page_addr,
    output logic      [RC_OUT_W-1:0] o_ref_count,
    output logic      [FREE_W-1:0]   o_free_count
);

    localparam int IDX_W     = $clog2(PAGES);
    localparam int FREE_SPAN = (FIRST_PAGE < PAGES) ? (PAGES - FIRST_PAGE) : 0;
    localparam int INIT_FREE = (FREE_SPAN > 8191) ? 8191 : FREE_SPAN;
    localparam logic [IDX_W-1:0] INIT_HEAD =
        (FIRST_PAGE < PAGES) ? IDX_W'(PAGES - 1) : '0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    t_state r_state, n_state;
    t_req   r_req;
    logic [IDX_W-1:0]  r_sweep;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [FREE_W-1:0] r_free, n_free;
    logic [IDX_W-1:0]  r_ref_addr;

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [ADDR_W-1:0]   r_page_addr;
    logic [RC_OUT_W-1:0] r_ref_count;
    logic [FREE_W-1:0]   r_free_count;

    logic                in_acc, proceed;
    logic [31:0]         in_idx32, ex_idx32, head32, rc32;
    logic [IDX_W-1:0]    ex_idx;
    logic [IDX_W-1:0]    link_rdata, link_wdata, link_waddr;
    logic [REF_BITS-1:0] ref_rdata, ref_wdata, ref_up, ref_down, rc_new;
    logic [IDX_W-1:0]    ref_waddr;
    logic                link_we, ref_we;
    logic [STAT_W-1:0]   ex_status;
    logic [ADDR_W-1:0]   ex_paddr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign proceed  = !r_out_valid || !i_out_stall;
    assign in_idx32 = 32'(i_phys_addr[ADDR_W-1:PAGE_SHIFT]);
    assign ex_idx32 = 32'(r_req.phys_addr[ADDR_W-1:PAGE_SHIFT]);
    assign ex_idx   = ex_idx32[IDX_W-1:0];
    assign head32   = 32'(r_head) << PAGE_SHIFT;
    assign ref_up   = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + 1'b1;
    assign ref_down = (ref_rdata == '0) ? ref_rdata : ref_rdata - 1'b1;

    pfa_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (in_acc),
        .i_raddr (r_head),
        .o_rdata (link_rdata)
    );

    pfa_ram #(.WIDTH(REF_BITS), .DEPTH(PAGES)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_re    (in_acc),
        .i_raddr ((i_req_type == RQ_ALLOC) ? r_head : in_idx32[IDX_W-1:0]),
        .o_rdata (ref_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_free     = r_free;
        link_we    = 1'b0;
        link_waddr = ex_idx;
        link_wdata = (r_free != '0) ? r_head : '0;
        ref_we     = 1'b0;
        ref_waddr  = r_ref_addr;
        ref_wdata  = ref_rdata;
        rc_new     = '0;
        ex_status  = STAT_OK;
        ex_paddr   = '0;
        o_in_stall = (r_state != ST_IDLE);

        case (r_state)
            ST_SWEEP: begin
                link_we    = 1'b1;
                link_waddr = r_sweep;
                link_wdata = (32'(r_sweep) > 32'(FIRST_PAGE)) ? r_sweep - 1'b1 : '0;
                ref_we     = 1'b1;
                ref_waddr  = r_sweep;
                ref_wdata  = '0;
                if (r_sweep == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_req.req_type)
                    RQ_ALLOC: begin
                        if (r_free == '0) begin
                            ex_status = STAT_OOM;
                        end else begin
                            ref_wdata = ref_up;
                            ref_we    = proceed;
                            rc_new    = ref_up;
                            ex_paddr  = head32[ADDR_W-1:0];
                            n_head    = link_rdata;
                            n_free    = r_free - 1'b1;
                        end
                    end
                    RQ_FREE: begin
                        if (r_req.phys_addr[PAGE_SHIFT-1:0] != '0 ||
                            ex_idx32 < 32'(FIRST_PAGE) || ex_idx32 >= 32'(PAGES)) begin
                            ex_status = STAT_BAD;
                        end else begin
                            link_we   = proceed;
                            ref_wdata = ref_down;
                            ref_we    = proceed;
                            rc_new    = ref_down;
                            n_head    = ex_idx;
                            n_free    = (r_free == FREE_MAX) ? r_free : r_free + 1'b1;
                        end
                    end
                    RQ_INC, RQ_DEC, RQ_READ: begin
                        if (ex_idx32 >= 32'(PAGES)) begin
                            ex_status = STAT_BAD;
                        end else if (r_req.req_type == RQ_INC) begin
                            ref_wdata = ref_up;
                            ref_we    = proceed;
                            rc_new    = ref_up;
                        end else if (r_req.req_type == RQ_DEC) begin
                            ref_wdata = ref_down;
                            ref_we    = proceed;
                            rc_new    = ref_down;
                        end else begin
                            rc_new = ref_rdata;
                        end
                    end
                    default: begin
                        ex_status = STAT_OK;
                    end
                endcase
                if (proceed) begin
                    n_state = ST_IDLE;
                end else begin
                    n_head = r_head;
                    n_free = r_free;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign rc32 = 32'(rc_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_head      <= INIT_HEAD;
            r_free      <= FREE_W'(INIT_FREE);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            if (r_state == ST_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (r_state == ST_EXEC && proceed) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.req_type  <= i_req_type;
            r_req.phys_addr <= i_phys_addr;
            r_ref_addr      <= (i_req_type == RQ_ALLOC) ? r_head : in_idx32[IDX_W-1:0];
        end
        if (r_state == ST_EXEC && proceed) begin
            r_status     <= ex_status;
            r_page_addr  <= ex_paddr;
            r_ref_count  <= rc32[RC_OUT_W-1:0];
            r_free_count <= n_free;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_page_addr  = r_page_addr;
    assign o_ref_count  = r_ref_count;
    assign o_free_count = r_free_count;

endmodule

`default_nettype wire

[sv/pfa_checker.sv]
// Port-level checker of the page frame allocator, bound to the top level.
// Depends on pfa_pkg and on the assertion macro header.
`default_nettype none
`include "page_frame_allocator_refcount_macros.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [STAT_W-1:0]   o_status,
    input wire logic [ADDR_W-1:0]   o_page_addr,
    input wire logic [RC_OUT_W-1:0] o_ref_count
);

    `PFA_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "request accepted twice in a row")
    `PFA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_page_addr) && $stable(o_ref_count), "stalled result changed")
    `PFA_ASSERT_NOW(a_fail_zero, o_out_valid && (o_status == STAT_OOM || o_status == STAT_BAD), o_page_addr == '0 && o_ref_count == '0, "failed request reports a page or count")
    `PFA_ASSERT_NOW(a_page_aligned, o_out_valid, o_page_addr[PAGE_SHIFT-1:0] == '0, "reported page address is not aligned")

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (.*);

`default_nettype wire
